// ----- sv/evad_pkg.sv -----
// ----------------------------------------------------------------------------
// evad_pkg
// Shared types, register indexes and reset values for the energy-based
// voice activity detector.
// ----------------------------------------------------------------------------
`default_nettype none

package evad_pkg;

  localparam int unsigned MAX_CHUNK_SAMPLES_DEF = 4096;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_VAD_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEECH_MS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_SILENCE_MS  = 3'd4;

  // Register reset values
  localparam logic [15:0] START_THR_RST   = 16'd655;
  localparam logic [15:0] END_THR_RST     = 16'd328;
  localparam logic [15:0] MIN_SPEECH_RST  = 16'd300;
  localparam logic [15:0] END_SILENCE_RST = 16'd800;

  // Thresholds are kept squared
  localparam logic [31:0] START_SQ_RST = 32'(START_THR_RST) * 32'(START_THR_RST);
  localparam logic [31:0] END_SQ_RST   = 32'(END_THR_RST) * 32'(END_THR_RST);

  typedef struct packed {
    logic signed [15:0] sample;
    logic               chunk_last;
    logic [31:0]        now_ms;
    logic               start_allowed;
  } in_item_t;

  typedef struct packed {
    logic speech_started;
    logic speech_ended;
    logic speech_active;
    logic chunk_loud;
    logic chunk_overflow;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic accum;
    logic mul;
    logic decide;
  } evad_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic chunk_last;
    logic out_free;
  } evad_sts_t;

endpackage

`default_nettype wire

// ----- sv/energy_voice_activity_detector_unit.sv -----
// Each sample is captured and squared in the 16x16 multiplier, then its square
// is added into the chunk energy. The sample that closes a chunk goes on to
// form threshold^2 x sample count for both thresholds, then to decide the
// speech state and load the result register; the decision waits while the
// previous result still waits to be taken. One result leaves per chunk.
// Configuration writes are always taken (cfg_ready stays high) and must land
// only while the block is idle; thresholds are squared as they are written.
// ----------------------------------------------------------------------------
// energy_voice_activity_detector_unit
// Energy-based voice activity detector over chunked signed 16-bit PCM.
// ----------------------------------------------------------------------------
`default_nettype none

module energy_voice_activity_detector_unit #(
  parameter int unsigned MAX_CHUNK_SAMPLES = evad_pkg::MAX_CHUNK_SAMPLES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire evad_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output evad_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [evad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [evad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import evad_pkg::*;

  evad_cmd_t cmd;
  evad_sts_t sts;

  assign cfg_ready = 1'b1;

  evad_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  evad_dp #(
    .MAX_CHUNK_SAMPLES (MAX_CHUNK_SAMPLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- sv/evad_ctrl.sv -----
// ----------------------------------------------------------------------------
// evad_ctrl
// Sequencer: capture a sample, accumulate it, and on the last sample of a
// chunk run the threshold products and the speech decision.
// ----------------------------------------------------------------------------
`default_nettype none

module evad_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire evad_pkg::evad_sts_t  sts,
  output evad_pkg::evad_cmd_t       cmd
);
  import evad_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_MUL,
    ST_DEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = sts.chunk_last ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        // hold until the result register can take the transaction
        if (sts.out_free) begin
          cmd.decide = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == ST_IDLE);
    end
  end

endmodule

`default_nettype wire

// ----- sv/evad_dp.sv -----
// ----------------------------------------------------------------------------
// evad_dp
// Datapath: squaring multiplier, energy accumulator, threshold products,
// speech state with timers, configuration registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module evad_dp #(
  parameter int unsigned MAX_CHUNK_SAMPLES = evad_pkg::MAX_CHUNK_SAMPLES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire evad_pkg::in_item_t              in_data,
  input  wire evad_pkg::evad_cmd_t             cmd,
  output evad_pkg::evad_sts_t                  sts,
  input  wire logic                            cfg_valid,
  input  wire logic [evad_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [evad_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output evad_pkg::out_item_t                  out_data
);
  import evad_pkg::*;

  localparam int unsigned TALLY_W = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int unsigned SUM_W   = 31 + $clog2(MAX_CHUNK_SAMPLES);
  localparam int unsigned PROD_W  = 32 + TALLY_W;
  localparam logic [TALLY_W-1:0] TALLY_MAX = TALLY_W'(MAX_CHUNK_SAMPLES);

  // configuration
  logic        vad_en_r;
  logic [31:0] start_sq_r;
  logic [31:0] end_sq_r;
  logic [15:0] min_speech_r;
  logic [15:0] end_silence_r;

  // captured item
  logic [30:0] sq_r;
  logic        last_r;
  logic [31:0] now_r;
  logic        allowed_r;

  // chunk accumulation
  logic [SUM_W-1:0]   sum_r;
  logic [TALLY_W-1:0] tally_r;
  logic               ovf_r;
  logic [PROD_W-1:0]  prod_start_r;
  logic [PROD_W-1:0]  prod_end_r;

  // speech state
  logic        active_r;
  logic [31:0] start_time_r;
  logic [31:0] loud_time_r;

  logic        out_valid_r;
  out_item_t   out_data_r;

  logic [15:0] mag;
  logic [31:0] sq_full;
  logic [31:0] cfg_sq;
  logic [PROD_W-1:0] sum_ext;
  logic        loud_start;
  logic        loud_end;
  logic        active_nxt;
  logic [31:0] start_time_nxt;
  logic [31:0] loud_time_nxt;
  logic        started;
  logic        ended;
  logic [31:0] since_start;
  logic [31:0] since_loud;
  logic        out_free;

  assign mag      = in_data.sample[15] ? 16'(-in_data.sample) : 16'(in_data.sample);
  assign sq_full  = mag * mag;
  assign cfg_sq   = cfg_data * cfg_data;
  assign sum_ext  = PROD_W'(sum_r);
  assign out_free = !out_valid_r || out_ready;

  assign sts.chunk_last = last_r;
  assign sts.out_free   = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign loud_start = (sum_ext >= prod_start_r);
  assign loud_end   = (sum_ext >= prod_end_r);

  always_comb begin
    active_nxt     = active_r;
    start_time_nxt = start_time_r;
    loud_time_nxt  = loud_time_r;
    started        = 1'b0;
    ended          = 1'b0;
    since_start    = '0;
    since_loud     = '0;
    if (!vad_en_r) begin
      active_nxt = 1'b0;
    end else begin
      if (!active_r && loud_start && allowed_r) begin
        active_nxt     = 1'b1;
        start_time_nxt = now_r;
        loud_time_nxt  = now_r;
        started        = 1'b1;
      end
      if (active_nxt) begin
        if (loud_end) begin
          loud_time_nxt = now_r;
        end
        // elapsed times wrap modulo 2^32
        since_start = now_r - start_time_nxt;
        since_loud  = now_r - loud_time_nxt;
        if ((since_start >= 32'(min_speech_r)) && (since_loud >= 32'(end_silence_r))) begin
          active_nxt = 1'b0;
          ended      = 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sq_r      <= sq_full[30:0];
      last_r    <= in_data.chunk_last;
      now_r     <= in_data.now_ms;
      allowed_r <= in_data.start_allowed;
    end
    if (cmd.mul) begin
      prod_start_r <= start_sq_r * tally_r;
      prod_end_r   <= end_sq_r * tally_r;
    end
    if (cmd.decide) begin
      out_data_r.speech_started <= started;
      out_data_r.speech_ended   <= ended;
      out_data_r.speech_active  <= active_nxt;
      out_data_r.chunk_loud     <= loud_end;
      out_data_r.chunk_overflow <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vad_en_r      <= 1'b0;
      start_sq_r    <= START_SQ_RST;
      end_sq_r      <= END_SQ_RST;
      min_speech_r  <= MIN_SPEECH_RST;
      end_silence_r <= END_SILENCE_RST;
      sum_r         <= '0;
      tally_r       <= '0;
      ovf_r         <= 1'b0;
      active_r      <= 1'b0;
      start_time_r  <= '0;
      loud_time_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_VAD_ENABLE: begin
            vad_en_r <= cfg_data[0];
            active_r <= 1'b0;
          end
          CFG_START_THRESHOLD: start_sq_r    <= cfg_sq;
          CFG_END_THRESHOLD:   end_sq_r      <= cfg_sq;
          CFG_MIN_SPEECH_MS:   min_speech_r  <= cfg_data;
          CFG_END_SILENCE_MS:  end_silence_r <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.accum) begin
        // drop samples past the chunk limit
        if (tally_r < TALLY_MAX) begin
          sum_r   <= sum_r + SUM_W'(sq_r);
          tally_r <= tally_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end

      if (cmd.decide) begin
        active_r     <= active_nxt;
        start_time_r <= start_time_nxt;
        loud_time_r  <= loud_time_nxt;
        sum_r        <= '0;
        tally_r      <= '0;
        ovf_r        <= 1'b0;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/evad_chk.sv -----
// ----------------------------------------------------------------------------
// evad_chk
// Port-level checks on the detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module evad_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire evad_pkg::out_item_t out_data
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // every captured sample is accumulated before the next one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.speech_started && !out_data.speech_ended
      |-> out_data.speech_active)
    else $error("speech started but not active");

  a_end_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.speech_ended |-> !out_data.speech_active)
    else $error("speech ended but still active");

endmodule

bind energy_voice_activity_detector_unit evad_chk u_evad_chk (.*);

`default_nettype wire

// ----- dv/tb_energy_voice_activity_detector_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_energy_voice_activity_detector_unit
// Self-checking bench for the energy-based voice activity detector. Streams
// chunked PCM samples under several register settings. A cycle-free predictor
// builds the per-chunk verdict for every accepted sample, and each returned
// verdict is compared field by field in arrival order. Handshake gaps on both
// sides vary by phase, and one long result back-pressure fills the block.
// ----------------------------------------------------------------------------
module tb_energy_voice_activity_detector_unit;
  import evad_pkg::*;

  localparam int unsigned CHUNK_CAP      = MAX_CHUNK_SAMPLES_DEF;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_ITEMS   = 1080;
  localparam int unsigned RANDOM_PHASES  = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  energy_voice_activity_detector_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Detector registers as the bench sees them
  logic        vad_on;
  logic [15:0] thr_start;
  logic [15:0] thr_end;
  logic [15:0] min_speech;
  logic [15:0] quiet_limit;

  // Detector state as the bench sees it
  logic        speaking;
  logic [31:0] speech_t0;
  logic [31:0] loud_t;
  logic [63:0] energy;
  int unsigned tally;
  logic        chunk_ovf;

  in_item_t    sample_q[$];
  out_item_t   verdict_q[$];
  int unsigned pushed_cnt   = 0;
  int unsigned taken_cnt    = 0;
  int unsigned err_cnt      = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned hold_req     = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  logic [31:0] stamp_ms     = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_VAD_ENABLE: begin
        vad_on   = val[0];
        speaking = 1'b0;
      end
      CFG_START_THRESHOLD: thr_start   = val;
      CFG_END_THRESHOLD:   thr_end     = val;
      CFG_MIN_SPEECH_MS:   min_speech  = val;
      CFG_END_SILENCE_MS:  quiet_limit = val;
      default: ;
    endcase
  endtask

  // Accumulate one sample; on the closing sample queue the chunk verdict
  task automatic vad_predict(input in_item_t it);
    int          s;
    logic [63:0] mag;
    logic        hot_start;
    logic        hot_end;
    logic [31:0] since_start;
    logic [31:0] since_loud;
    out_item_t   v;
    if (tally < CHUNK_CAP) begin
      s      = it.sample;
      mag    = 64'((s < 0) ? -s : s);
      energy = energy + mag * mag;
      tally++;
    end else begin
      chunk_ovf = 1'b1;
    end
    if (!it.chunk_last) return;

    hot_start = energy >= 64'(thr_start) * 64'(thr_start) * 64'(tally);
    hot_end   = energy >= 64'(thr_end) * 64'(thr_end) * 64'(tally);
    v = '0;
    v.chunk_loud     = hot_end;
    v.chunk_overflow = chunk_ovf;
    if (!vad_on) begin
      speaking = 1'b0;
    end else begin
      if (!speaking && hot_start && it.start_allowed) begin
        speaking         = 1'b1;
        speech_t0        = it.now_ms;
        loud_t           = it.now_ms;
        v.speech_started = 1'b1;
      end
      if (speaking) begin
        if (hot_end) loud_t = it.now_ms;
        since_start = it.now_ms - speech_t0;
        since_loud  = it.now_ms - loud_t;
        if (since_start >= 32'(min_speech) && since_loud >= 32'(quiet_limit)) begin
          speaking       = 1'b0;
          v.speech_ended = 1'b1;
        end
      end
    end
    v.speech_active = speaking;
    energy    = '0;
    tally     = 0;
    chunk_ovf = 1'b0;
    verdict_q.push_back(v);
  endtask

  function automatic void cmp_bit(input string name, input logic want, input logic got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch: expected %b, actual %b", $time, name, want, got);
    end
  endfunction

  // Check results first, then fold in register writes and new samples
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      vad_on      = 1'b0;
      thr_start   = START_THR_RST;
      thr_end     = END_THR_RST;
      min_speech  = MIN_SPEECH_RST;
      quiet_limit = END_SILENCE_RST;
      speaking    = 1'b0;
      speech_t0   = '0;
      loud_t      = '0;
      energy      = '0;
      tally       = 0;
      chunk_ovf   = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          err_cnt++;
          $display("%0t: verdict with none expected: actual %p", $time, out_data);
        end else begin
          want = verdict_q.pop_front();
          cmp_bit("speech_started", want.speech_started, out_data.speech_started);
          cmp_bit("speech_ended", want.speech_ended, out_data.speech_ended);
          cmp_bit("speech_active", want.speech_active, out_data.speech_active);
          cmp_bit("chunk_loud", want.chunk_loud, out_data.chunk_loud);
          cmp_bit("chunk_overflow", want.chunk_overflow, out_data.chunk_overflow);
        end
      end
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        taken_cnt++;
        vad_predict(in_data);
      end
    end
  end

  // Sample driver: advance only when the current transaction is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        in_valid <= 1'b1;
        in_data  <= sample_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result acceptor with random stalls and an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Queue one chunk of n samples drawn from [lo, hi]; the last one closes it
  task automatic add_chunk(input int unsigned n, input int lo, input int hi,
                           input logic allow, input logic [31:0] step);
    in_item_t it;
    stamp_ms = stamp_ms + step;
    for (int unsigned i = 0; i < n; i++) begin
      it.sample        = 16'(lo + int'($urandom_range(0, hi - lo)));
      it.chunk_last    = (i == n - 1);
      it.now_ms        = it.chunk_last ? stamp_ms : $urandom();
      it.start_allowed = it.chunk_last ? allow : 1'($urandom_range(0, 1));
      sample_q.push_back(it);
      pushed_cnt++;
    end
  endtask

  // Wait until every sample is taken and every verdict is back, then settle
  task automatic drain();
    while (taken_cnt != pushed_cnt || verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic logic [15:0] pick_span();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 1500));
    endcase
  endfunction

  task automatic random_config();
    cfg_write(CFG_VAD_ENABLE, 16'($urandom_range(0, 9) != 0));
    cfg_write(CFG_START_THRESHOLD, pick_level());
    if ($urandom_range(0, 1) == 0) cfg_write(CFG_END_THRESHOLD, thr_start >> 1);
    else cfg_write(CFG_END_THRESHOLD, pick_level());
    cfg_write(CFG_MIN_SPEECH_MS, pick_span());
    cfg_write(CFG_END_SILENCE_MS, pick_span());
  endtask

  // Chunk loudness is drawn around the current thresholds so that speech
  // starts, holds and times out
  task automatic random_chunk();
    int unsigned n;
    int unsigned a;
    logic [31:0] step;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
    case ($urandom_range(0, 9))
      0, 1, 2: a = thr_end / 2;
      3, 4:    a = thr_start;
      5, 6, 7: a = 3 * thr_start + 50;
      default: a = 32768;
    endcase
    if (a > 32768) a = 32768;
    step = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 400);
    add_chunk(n, -int'(a), (a > 32767) ? 32767 : int'(a), $urandom_range(0, 3) != 0, step);
  endtask

  initial begin
    int unsigned phase_start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_gap_pct = 9;
    recv_gap_pct = 88;

    // Detection off after reset: loud chunks still report loudness only
    add_chunk(1, -32768, -32768, 1'b1, 5);
    add_chunk(3, 32767, 32767, 1'b1, 5);
    drain();

    cfg_write(CFG_VAD_ENABLE, 16'd1);
    cfg_write(CFG_START_THRESHOLD, 16'd655);
    cfg_write(CFG_END_THRESHOLD, 16'd328);
    cfg_write(CFG_MIN_SPEECH_MS, 16'd300);
    cfg_write(CFG_END_SILENCE_MS, 16'd800);
    cfg_write(CFG_UNMAPPED, 16'($urandom()));
    stamp_ms = 32'd1000;
    add_chunk(2, 654, 654, 1'b1, 10);
    add_chunk(2, 655, 655, 1'b0, 10);
    add_chunk(2, -655, -655, 1'b1, 10);
    add_chunk(1, 0, 0, 1'b1, 100);
    add_chunk(1, 327, 327, 1'b1, 850);
    // Speech across the timestamp wrap
    stamp_ms = 32'hFFFF_FF00;
    add_chunk(4, -32768, -32768, 1'b1, 0);
    add_chunk(1, 0, 0, 1'b1, 900);
    drain();

    // Zero thresholds and times: start and end on one chunk
    cfg_write(CFG_START_THRESHOLD, 16'd0);
    cfg_write(CFG_END_THRESHOLD, 16'd0);
    cfg_write(CFG_MIN_SPEECH_MS, 16'd0);
    cfg_write(CFG_END_SILENCE_MS, 16'd0);
    add_chunk(1, 0, 0, 1'b1, 1);
    add_chunk(1, 0, 0, 1'b0, 1);
    drain();

    // Enable write drops active speech
    cfg_write(CFG_MIN_SPEECH_MS, 16'hFFFF);
    cfg_write(CFG_END_SILENCE_MS, 16'hFFFF);
    add_chunk(1, 5, 5, 1'b1, 1);
    drain();
    cfg_write(CFG_VAD_ENABLE, 16'd1);
    add_chunk(1, 5, 5, 1'b1, 1);
    drain();

    // Full-scale chunks: energy exactly on the start boundary, then mixed extremes
    cfg_write(CFG_START_THRESHOLD, 16'h8000);
    cfg_write(CFG_END_THRESHOLD, 16'hFFFF);
    cfg_write(CFG_VAD_ENABLE, 16'd1);
    add_chunk(128, -32768, -32768, 1'b1, 1);
    add_chunk(64, -32768, 32767, 1'b1, 70000);
    drain();

    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      case (p / 3)
        0: begin
          send_gap_pct = 9;
          recv_gap_pct = 88;
        end
        1: begin
          send_gap_pct = 88;
          recv_gap_pct = 9;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      random_config();
      stamp_ms    = $urandom();
      phase_start = pushed_cnt;
      while (pushed_cnt - phase_start < RANDOM_ITEMS / RANDOM_PHASES) random_chunk();
      // Back-pressure the results while samples keep coming
      if (p == 6) hold_req++;
      drain();
    end

    repeat (20) @(posedge clk);
    if (err_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
